/* src/utf8hc_pkg.sv */
// ----------------------------------------------------------------------------
// utf8hc_pkg
// Shared types and helpers for the utf-8 decoder with han classification.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8hc_pkg;

  localparam int CodeWidth   = 21;
  localparam int CountWidth  = 3;
  localparam int JobqDepth   = 2;

  // work handed from the front end to the back end for one accepted byte:
  // up to three lone bytes, then at most one closing character
  typedef struct packed {
    logic [2:0][7:0]        singles;
    logic [1:0]             nsingle;
    logic                   has_last;
    logic [CodeWidth-1:0]   last_code;
    logic [CountWidth-1:0]  last_cnt;
    logic                   last_han;
    logic                   last_fin;
  } job_t;

  function automatic logic is_han(input logic [CodeWidth-1:0] v);
    return v inside {
      21'h03007, [21'h0e815:21'h0e864], 21'h0fa18,
      [21'h03400:21'h04dbf], [21'h04e00:21'h09fff], [21'h0f900:21'h0faff],
      [21'h20000:21'h2a6df], [21'h2a703:21'h2b73f], [21'h2b740:21'h2b81d],
      [21'h2b825:21'h2bf6e], [21'h2c029:21'h2ce93], 21'h2d016,
      [21'h2d11b:21'h2ebd9], [21'h2f80a:21'h2fa1f], [21'h30000:21'h3134a],
      [21'h300f7:21'h31288], 21'h30edd, 21'h30ede, [21'h31350:21'h32389]
    };
  endfunction

endpackage

`default_nettype wire

/* src/utf8_decoder_han_classifier_core.sv */
// ----------------------------------------------------------------------------
// utf8_decoder_han_classifier_core
// Lenient utf-8 decoder that tags each character with a han range flag.
// ----------------------------------------------------------------------------
// input side is a queue write port: a beat moves when push is high and full
// is low, carrying in_byte and end_of_text (set on the last byte of a text).
// result side is a queue read port: while empty is low the oldest result sits
// on code_point, byte_count, han_flag and final_char, and a beat moves when
// pop is high. one input byte gives zero to four results.
// a byte is taken every cycle while the job queue has room. the front end
// decodes in the cycle the byte arrives and, if it yields results, writes
// a job into the queue; the first result shows once the back end has loaded
// that job. the back end gives out one result per cycle while pop is high,
// so a byte that breaks a sequence and yields k results holds the back end
// until all k are popped. when pop stays low results back up into the job
// queue, and full rises once it holds QUEUE_DEPTH jobs; nothing is dropped.
// synchronous reset empties the queue and drops any pending sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decoder_han_classifier_core #(
  parameter int QUEUE_DEPTH = utf8hc_pkg::JobqDepth
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [7:0]                       in_byte,
  input  wire logic                             end_of_text,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [utf8hc_pkg::CodeWidth-1:0]      code_point,
  output logic [utf8hc_pkg::CountWidth-1:0]     byte_count,
  output logic                                  han_flag,
  output logic                                  final_char
);
  import utf8hc_pkg::*;

  job_t front_job;
  logic front_valid;
  logic take;
  job_t q_data;
  logic q_full;
  logic q_nempty;
  logic q_rd;

  assign full = q_full;
  assign take = push && !q_full;

  utf8hc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .job         (front_job),
    .job_valid   (front_valid)
  );

  utf8hc_jobq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_job),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .nempty  (q_nempty)
  );

  utf8hc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (q_data),
    .q_nempty   (q_nempty),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .code_point (code_point),
    .byte_count (byte_count),
    .han_flag   (han_flag),
    .final_char (final_char)
  );

endmodule

`default_nettype wire

/* src/utf8hc_front.sv */
// ----------------------------------------------------------------------------
// utf8hc_front
// Takes one byte per beat, tracks the pending sequence and builds a job.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8hc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        in_byte,
  input  wire logic              end_of_text,
  output utf8hc_pkg::job_t       job,
  output logic                   job_valid
);
  import utf8hc_pkg::*;

  logic [7:0]             lead;
  logic [1:0][7:0]        held;
  logic [1:0]             held_count;
  logic [2:0]             exp_len;
  logic [CodeWidth-1:0]   partial;

  logic [7:0]             lead_next;
  logic [1:0][7:0]        held_next;
  logic [1:0]             held_count_next;
  logic [2:0]             exp_len_next;
  logic [CodeWidth-1:0]   partial_next;

  logic                   is_cont;
  logic [2:0]             f_len;
  logic [4:0]             f_bits;
  logic [CodeWidth-1:0]   code;
  logic                   do_fresh;

  assign is_cont = (in_byte[7:6] == 2'b10);
  assign code    = {partial[CodeWidth-7:0], in_byte[5:0]};

  always_comb begin
    f_len  = 3'd1;
    f_bits = 5'd0;
    if (in_byte[7:5] == 3'b110) begin
      f_len  = 3'd2;
      f_bits = in_byte[4:0];
    end else if (in_byte[7:4] == 4'b1110) begin
      f_len  = 3'd3;
      f_bits = {1'b0, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      f_len  = 3'd4;
      f_bits = {2'b00, in_byte[2:0]};
    end
  end

  always_comb begin
    job             = '0;
    lead_next       = lead;
    held_next       = held;
    held_count_next = held_count;
    exp_len_next    = exp_len;
    partial_next    = partial;
    do_fresh        = 1'b0;

    if (exp_len == 3'd0) begin
      do_fresh = 1'b1;
    end else if (is_cont) begin
      if ({1'b0, held_count} + 3'd2 >= exp_len) begin
        job.has_last  = 1'b1;
        job.last_code = code;
        job.last_cnt  = exp_len;
        job.last_fin  = end_of_text;
        lead_next       = '0;
        held_next       = '0;
        held_count_next = '0;
        exp_len_next    = '0;
        partial_next    = '0;
      end else if (end_of_text) begin
        job.singles   = {held[1], held[0], lead};
        job.nsingle   = held_count + 2'd1;
        job.has_last  = 1'b1;
        job.last_code = {{(CodeWidth-8){1'b0}}, in_byte};
        job.last_cnt  = 3'd1;
        job.last_fin  = 1'b1;
        lead_next       = '0;
        held_next       = '0;
        held_count_next = '0;
        exp_len_next    = '0;
        partial_next    = '0;
      end else begin
        held_next[held_count[0]] = in_byte;
        held_count_next          = held_count + 2'd1;
        partial_next             = code;
      end
    end else begin
      // broken sequence: lead and held bytes go out alone
      job.singles     = {held[1], held[0], lead};
      job.nsingle     = held_count + 2'd1;
      held_next       = '0;
      held_count_next = '0;
      do_fresh        = 1'b1;
    end

    if (do_fresh) begin
      if (f_len == 3'd1 || end_of_text) begin
        job.has_last  = 1'b1;
        job.last_code = {{(CodeWidth-8){1'b0}}, in_byte};
        job.last_cnt  = 3'd1;
        job.last_fin  = end_of_text;
        lead_next       = '0;
        held_next       = '0;
        held_count_next = '0;
        exp_len_next    = '0;
        partial_next    = '0;
      end else begin
        lead_next       = in_byte;
        held_count_next = '0;
        exp_len_next    = f_len;
        partial_next    = {{(CodeWidth-5){1'b0}}, f_bits};
      end
    end

    job.last_han = is_han(job.last_code);
  end

  assign job_valid = take && (job.nsingle != 2'd0 || job.has_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      lead       <= '0;
      held       <= '0;
      held_count <= '0;
      exp_len    <= '0;
      partial    <= '0;
    end else if (take) begin
      lead       <= lead_next;
      held       <= held_next;
      held_count <= held_count_next;
      exp_len    <= exp_len_next;
      partial    <= partial_next;
    end
  end

endmodule

`default_nettype wire

/* src/utf8hc_jobq.sv */
// ----------------------------------------------------------------------------
// utf8hc_jobq
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8hc_jobq #(
  parameter int DEPTH = utf8hc_pkg::JobqDepth
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire utf8hc_pkg::job_t  wr_data,
  output logic                   full,
  input  wire logic              rd_en,
  output utf8hc_pkg::job_t       rd_data,
  output logic                   nempty
);
  import utf8hc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(DEPTH));
  assign nempty  = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CntW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/utf8hc_back.sv */
// ----------------------------------------------------------------------------
// utf8hc_back
// Holds the current job and hands out its results one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8hc_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire utf8hc_pkg::job_t                 q_data,
  input  wire logic                             q_nempty,
  output logic                                  q_rd,
  input  wire logic                             pop,
  output logic                                  empty,
  output logic [utf8hc_pkg::CodeWidth-1:0]      code_point,
  output logic [utf8hc_pkg::CountWidth-1:0]     byte_count,
  output logic                                  han_flag,
  output logic                                  final_char
);
  import utf8hc_pkg::*;

  job_t       cur;
  logic       cur_v;
  logic [1:0] idx;

  logic [2:0] total;
  logic       is_single;
  logic       last_item;
  logic       take_out;

  assign total     = {1'b0, cur.nsingle} + {2'b00, cur.has_last};
  assign is_single = (idx < cur.nsingle);
  assign last_item = ({1'b0, idx} + 3'd1 == total);
  assign take_out  = pop && cur_v;
  assign q_rd      = q_nempty && (!cur_v || (take_out && last_item));
  assign empty     = !cur_v;

  always_comb begin
    if (is_single) begin
      code_point = {{(CodeWidth-8){1'b0}}, cur.singles[idx]};
      byte_count = CountWidth'(1);
      han_flag   = 1'b0;
      final_char = 1'b0;
    end else begin
      code_point = cur.last_code;
      byte_count = cur.last_cnt;
      han_flag   = cur.last_han;
      final_char = cur.last_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v <= 1'b0;
      idx   <= '0;
    end else if (q_rd) begin
      cur_v <= 1'b1;
      idx   <= '0;
    end else if (take_out) begin
      if (last_item) begin
        cur_v <= 1'b0;
        idx   <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

endmodule

`default_nettype wire
